// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Both expect signals named clk and rst
// in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// A clocked property that must hold outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// A condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, expr)
`endif
`endif

// ===== hw/rtl/fsg_pkg.sv =====
package fsg_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FAT_TYPE    = 2'd0;
  localparam logic [1:0] CFG_NUM_OBJECTS = 2'd1;
  localparam logic [1:0] CFG_FAT_START   = 2'd2;

  // Input commands.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Table constants.
  localparam int          SLOT_COUNT  = 16;
  localparam logic [17:0] CLUSTER_MAX = 18'h3ffff;
  localparam logic [15:0] EOC_FAT12   = 16'h0fff;
  localparam logic [15:0] EOC_FAT16   = 16'hffff;
  localparam logic [15:0] MEDIA_MASK  = 16'hfff8;
  localparam int          FIRST_CLUSTER = 2;

  typedef logic [17:0] cluster_count_t;
  typedef logic [63:0] word_t;

endpackage

// ===== hw/rtl/fsg_div3.sv =====
// Divider by three through a scaled reciprocal; start is registered into pend, then into done.
module fsg_div3 #(
  parameter int DW = 29
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  output logic          done,
  output logic [DW-1:0] quot,
  output logic [1:0]    rem
);

  // Reciprocal of three scaled by 2^SH; the rounding error stays below one
  // third of a unit for every DW-bit dividend, so the quotient is exact.
  localparam int            SH    = DW + 1;
  localparam int            PW    = 2 * DW;
  localparam logic [DW-1:0] RECIP = DW'((1 << SH) / 3 + 1);

  logic          pend;
  logic [DW-1:0] dvd;
  logic [PW-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      pend <= start;
      done <= pend;
    end
  end

  // The product is registered on start; the quotient bits are taken from it when pend is set.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      prod <= PW'(dividend) * PW'(RECIP);
    end
    if (pend) begin
      quot <= DW'(prod >> SH);
    end
  end

  // The remainder is below three, so the low two bits of x - 3q suffice.
  assign rem = 2'(dvd - DW'({quot, 1'b0}) - quot);

endmodule

// ===== hw/rtl/fat_sector_generator_top.sv =====
// FAT12/FAT16 allocation table sector generator.
// Input channel s_*: a load transaction (s_tuser = 0) stores one object's
// size as a cluster count; a read transaction (s_tuser = 1) asks for one
// table sector. The block accepts no input while it builds a sector. Each
// read yields 64 words on m_*, word index 0..63, with m_tlast on word 63.
// A sector is produced by walking its cluster entries one per cycle, while
// no full word waits in the accumulator, through a shared entry unit and
// packing them into a bit accumulator; a full word leaves while no entry is
// appended. FAT12 finds its first entry with a reciprocal divide by three.
// Objects are skipped one per cycle, likewise while no full word waits.
// Config port cfg_*: always ready; write only while idle.
// A stalled receiver holds the output word; the walk runs on until a full
// word waits, then stops until it is taken. Reset clears the configuration
// and the control state; stored cluster counts stay undefined until loaded.
// SECTOR_BYTES and CLUSTER_BYTES must be powers of two.
`include "assert_macros.svh"
module fat_sector_generator_top #(
  parameter int SECTOR_BYTES  = 512,
  parameter int CLUSTER_BYTES = 32768,
  parameter int MAX_OBJECTS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  // object_index[3:0], object_size[35:4], sector_address[51:36], zero pad
  input  logic [55:0] s_tdata,
  // command[0]
  input  logic        s_tuser,
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // word_data[63:0], word_index[69:64], zero pad
  output logic [71:0] m_tdata,
  output logic        m_tlast,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import fsg_pkg::*;

  localparam int SB_LOG = $clog2(SECTOR_BYTES);
  localparam int CB_LOG = $clog2(CLUSTER_BYTES);
  localparam int DW     = 16 + SB_LOG + 1;
  localparam int CW     = 16 + SB_LOG;
  localparam int ACC_W  = 80;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [1:0]  state;
  logic        fat_type;
  logic [3:0]  num_objects;
  logic [15:0] fat_start_sector;

  cluster_count_t clusters [SLOT_COUNT];

  // Walk registers.
  logic          zero_mode;
  logic [CW-1:0] cur_c;
  logic [CW-1:0] chain_s;
  logic [4:0]    obj;
  logic [3:0]    skip_bits;
  logic [ACC_W-1:0] acc;
  logic [6:0]    fill;
  logic [5:0]    widx;

  // Output register.
  word_t      out_word;
  logic [5:0] out_idx;

  // Input field views.
  logic        in_cmd;
  logic [3:0]  in_index;
  logic [31:0] in_size;
  logic [15:0] in_addr;
  assign in_cmd   = s_tuser;
  assign in_index = s_tdata[3:0];
  assign in_size  = s_tdata[35:4];
  assign in_addr  = s_tdata[51:36];

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata   = {2'b00, out_idx, out_word};
  assign m_tlast   = (out_idx == 6'd63);

  logic in_acc;
  assign in_acc = s_tvalid && s_tready;

  // Cluster count of a load: ceil(size / CLUSTER_BYTES), saturated.
  logic [32:0] size_round;
  logic [32:0] size_cl;
  cluster_count_t load_count;
  assign size_round = {1'b0, in_size} + 33'(CLUSTER_BYTES - 1);
  assign size_cl    = size_round >> CB_LOG;
  assign load_count = (size_cl > 33'(CLUSTER_MAX)) ? CLUSTER_MAX : size_cl[17:0];

  // Sector position relative to the table.
  logic [15:0] rel;
  logic        below;
  assign rel   = in_addr - fat_start_sector;
  assign below = (in_addr < fat_start_sector);

  // Divide 2 * base by three for the first FAT12 entry.
  logic          div_start;
  logic          div_done;
  logic [DW-1:0] div_quot;
  logic [1:0]    div_rem;
  assign div_start = in_acc && (in_cmd == CMD_READ) && !below && !fat_type;

  fsg_div3 #(.DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (DW'(rel) << (SB_LOG + 1)),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Shared entry unit: value of entry cur_c against the current object.
  logic [4:0]     lim;
  cluster_count_t n_cur;
  logic [CW-1:0]  chain_e;
  logic           in_obj;
  logic           skip_step;
  logic [15:0]    eoc;
  logic [15:0]    link;
  logic [15:0]    val;
  logic [15:0]    val_sh;
  logic [ACC_W-1:0] app_bits;
  logic [6:0]     app_w;

  assign lim     = (5'(num_objects) < 5'(MAX_OBJECTS)) ? 5'(num_objects)
                                                       : 5'(MAX_OBJECTS);
  assign n_cur   = clusters[obj[3:0]];
  assign chain_e = chain_s + CW'(n_cur);
  assign in_obj  = (obj < lim);
  assign skip_step = in_obj && ((n_cur == '0) || (cur_c >= chain_e));
  assign eoc     = fat_type ? EOC_FAT16 : EOC_FAT12;
  assign link    = (cur_c == chain_e - CW'(1)) ? eoc : 16'(cur_c + CW'(1));

  always_comb begin
    if (zero_mode) begin
      val = '0;
    end else if (cur_c == CW'(0)) begin
      val = eoc & MEDIA_MASK;
    end else if (cur_c == CW'(1)) begin
      val = eoc;
    end else if (in_obj && (cur_c >= chain_s)) begin
      val = link & eoc;
    end else begin
      val = '0;
    end
  end

  // Bit packer input: entries form a little-endian bit stream.
  assign val_sh   = val >> skip_bits;
  assign app_w    = (fat_type ? 7'd16 : 7'd12) - 7'(skip_bits);
  assign app_bits = ACC_W'(val_sh) << fill;

  logic out_free;
  logic emit;
  logic append;
  assign out_free = !m_tvalid || m_tready;
  assign emit     = (state == ST_RUN) && (fill >= 7'd64) && out_free;
  assign append   = (state == ST_RUN) && (fill < 7'd64) && !skip_step;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      fat_type         <= 1'b0;
      num_objects      <= '0;
      fat_start_sector <= '0;
      m_tvalid         <= 1'b0;
    end else begin
      // Configuration writes.
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_FAT_TYPE:    fat_type         <= cfg_data[0];
          CFG_NUM_OBJECTS: num_objects      <= cfg_data[3:0];
          CFG_FAT_START:   fat_start_sector <= cfg_data;
          default: ;
        endcase
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc && (in_cmd == CMD_READ)) begin
            state <= div_start ? ST_DIV : ST_RUN;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (emit && (widx == 6'd63)) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath: object store, walk and packer.
  always_ff @(posedge clk) begin
    if (in_acc && (in_cmd == CMD_LOAD)) begin
      clusters[in_index] <= load_count;
    end
    if (in_acc && (in_cmd == CMD_READ)) begin
      zero_mode <= below;
      cur_c     <= CW'(rel) << (SB_LOG - 1);
      chain_s   <= CW'(FIRST_CLUSTER);
      obj       <= '0;
      skip_bits <= '0;
      acc       <= '0;
      fill      <= '0;
      widx      <= '0;
    end
    if ((state == ST_DIV) && div_done) begin
      cur_c     <= div_quot[CW-1:0];
      skip_bits <= {div_rem, 2'b00};
    end
    if (emit) begin
      out_word <= acc[63:0];
      out_idx  <= widx;
      widx     <= widx + 1'b1;
      acc      <= acc >> 64;
      fill     <= fill - 7'd64;
    end else if (append) begin
      acc       <= acc | app_bits;
      fill      <= fill + app_w;
      cur_c     <= cur_c + CW'(1);
      skip_bits <= '0;
    end else if ((state == ST_RUN) && (fill < 7'd64) && skip_step) begin
      chain_s <= chain_e;
      obj     <= obj + 1'b1;
    end
  end

  `ASSERT_CLK(a_last_word, (m_tvalid && m_tlast) |-> (out_idx == 6'd63))
  `ASSERT_CLK(a_div_in_div, div_done |-> (state == ST_DIV))
  `ASSERT_NEVER(a_fill_range, (state == ST_RUN) && (fill > 7'(ACC_W - 1)))

endmodule
